### rtl/core/mmd_pkg.sv
package mmd_pkg;

  localparam int LEN_W = 11;
  localparam int COUNT_MAX = (1 << LEN_W) - 1;
  localparam int DEFAULT_MAX_SYSEX_LEN = 1024;

  // Status bytes and their boundaries
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] ST_REALTIME = 8'hF8;
  localparam logic [7:0] ST_COMMON   = 8'hF1;
  localparam logic [7:0] ST_NONE     = 8'h00;

  // Channel message types (upper nibble of status)
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_CTRL     = 4'hB;
  localparam logic [3:0] MSG_PROGRAM  = 4'hC;
  localparam logic [3:0] MSG_CHAN_PRS = 4'hD;
  localparam logic [3:0] MSG_BEND     = 4'hE;

  // Controller numbers
  localparam logic [6:0] CC_MODULATION = 7'd1;
  localparam logic [6:0] CC_DATA_ENTRY = 7'd6;
  localparam logic [6:0] CC_VOLUME     = 7'd7;
  localparam logic [6:0] CC_EXPRESSION = 7'd11;
  localparam logic [6:0] CC_HOLD       = 7'd64;
  localparam logic [6:0] CC_RPN_LSB    = 7'd100;
  localparam logic [6:0] CC_RPN_MSB    = 7'd101;
  localparam logic [6:0] CC_SOUND_OFF  = 7'd120;
  localparam logic [6:0] CC_NOTES_OFF  = 7'd123;

  localparam logic [6:0] RPN_NULL = 7'h7F;

  typedef enum logic [3:0] {
    EV_NOTE_ON    = 4'd0,
    EV_NOTE_OFF   = 4'd1,
    EV_PROGRAM    = 4'd2,
    EV_BEND       = 4'd3,
    EV_MODULATION = 4'd4,
    EV_VOLUME     = 4'd5,
    EV_EXPRESSION = 4'd6,
    EV_HOLD       = 4'd7,
    EV_SOUND_OFF  = 4'd8,
    EV_NOTES_OFF  = 4'd9,
    EV_BEND_SENS  = 4'd10,
    EV_SYSEX_BYTE = 4'd11,
    EV_SYSEX_END  = 4'd12,
    EV_RESET      = 4'd13
  } event_kind_t;

  typedef struct packed {
    logic [7:0]       running_status;
    logic             await_third;
    logic [6:0]       first_data;
    logic [6:0]       rpn_high;
    logic [6:0]       rpn_low;
    logic             in_sysex;
    logic [LEN_W-1:0] sysex_count;
    logic [2:0]       pattern_match;  // bit 0 GM, bit 1 XG, bit 2 GS
  } state_t;

  typedef struct packed {
    event_kind_t      kind;
    logic [3:0]       channel;
    logic [6:0]       number;
    logic [13:0]      value;
    logic [LEN_W-1:0] sysex_length;
  } event_t;

endpackage

### rtl/core/mmd_decode.sv
module mmd_decode #(
  parameter int MAX_SYSEX_LEN = mmd_pkg::DEFAULT_MAX_SYSEX_LEN
) (
  input  logic [7:0]      rx_byte,
  input  mmd_pkg::state_t st,
  output mmd_pkg::state_t st_nxt,
  output logic            ev_hit,
  output mmd_pkg::event_t ev
);
  import mmd_pkg::*;

  localparam logic [LEN_W-1:0] COUNT_CAP =
    (MAX_SYSEX_LEN > COUNT_MAX) ? LEN_W'(COUNT_MAX) : LEN_W'(MAX_SYSEX_LEN);

  function automatic logic [7:0] gm_pat(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h7E;
      2'd1:    r = 8'h7F;
      2'd2:    r = 8'h09;
      default: r = 8'h01;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xg_pat(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h43;
      3'd1:    r = 8'h10;
      3'd2:    r = 8'h4C;
      3'd5:    r = 8'h7E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gs_pat(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h41;
      4'd1:    r = 8'h10;
      4'd2:    r = 8'h42;
      4'd3:    r = 8'h12;
      4'd4:    r = 8'h40;
      4'd6:    r = 8'h7F;
      4'd8:    r = 8'h41;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  logic       msg_go;
  logic [6:0] d1;
  logic [6:0] d2;
  logic       sys_reset;

  always_comb begin
    st_nxt    = st;
    ev_hit    = 1'b0;
    ev        = '0;
    msg_go    = 1'b0;
    d1        = rx_byte[6:0];
    d2        = '0;
    sys_reset = 1'b0;

    if (st.in_sysex) begin
      if (rx_byte == ST_EOX) begin
        sys_reset = (st.pattern_match[0] && st.sysex_count >= LEN_W'(4)) ||
                    (st.pattern_match[1] && st.sysex_count >= LEN_W'(7)) ||
                    (st.pattern_match[2] && st.sysex_count >= LEN_W'(9));
        st_nxt.in_sysex = 1'b0;
        ev_hit = 1'b1;
        if (sys_reset) begin
          ev.kind = EV_RESET;
        end else begin
          ev.kind         = EV_SYSEX_END;
          ev.sysex_length = st.sysex_count;
        end
      end else begin
        // Drop a pattern at its first mismatching payload byte
        if (st.sysex_count < LEN_W'(4) && gm_pat(st.sysex_count[1:0]) != rx_byte)
          st_nxt.pattern_match[0] = 1'b0;
        if (st.sysex_count < LEN_W'(7) && xg_pat(st.sysex_count[2:0]) != rx_byte)
          st_nxt.pattern_match[1] = 1'b0;
        if (st.sysex_count < LEN_W'(9) && gs_pat(st.sysex_count[3:0]) != rx_byte)
          st_nxt.pattern_match[2] = 1'b0;
        if (st.sysex_count < COUNT_CAP)
          st_nxt.sysex_count = st.sysex_count + LEN_W'(1);
        ev_hit   = 1'b1;
        ev.kind  = EV_SYSEX_BYTE;
        ev.value = {6'd0, rx_byte};
      end
    end else if (rx_byte == ST_SYSEX) begin
      st_nxt.in_sysex       = 1'b1;
      st_nxt.sysex_count    = '0;
      st_nxt.pattern_match  = 3'b111;
      st_nxt.running_status = ST_NONE;
      st_nxt.await_third    = 1'b0;
    end else if (rx_byte >= ST_REALTIME) begin
      // realtime: no effect
    end else if (rx_byte >= ST_COMMON) begin
      st_nxt.running_status = ST_NONE;
      st_nxt.await_third    = 1'b0;
    end else if (rx_byte[7]) begin
      st_nxt.running_status = rx_byte;
      st_nxt.await_third    = 1'b0;
    end else if (st.await_third) begin
      st_nxt.await_third = 1'b0;
      msg_go = 1'b1;
      d1     = st.first_data;
      d2     = rx_byte[6:0];
    end else if (st.running_status == ST_NONE) begin
      // data without status: ignore
    end else if (st.running_status[7:4] == MSG_PROGRAM ||
                 st.running_status[7:4] == MSG_CHAN_PRS) begin
      msg_go = 1'b1;
    end else begin
      st_nxt.first_data  = rx_byte[6:0];
      st_nxt.await_third = 1'b1;
    end

    if (msg_go) begin
      ev.channel = st.running_status[3:0];
      unique case (st.running_status[7:4])
        MSG_NOTE_ON: begin
          ev_hit    = 1'b1;
          ev.number = d1;
          if (d2 == 7'd0) begin
            ev.kind = EV_NOTE_OFF;
          end else begin
            ev.kind  = EV_NOTE_ON;
            ev.value = {7'd0, d2};
          end
        end
        MSG_NOTE_OFF: begin
          ev_hit    = 1'b1;
          ev.kind   = EV_NOTE_OFF;
          ev.number = d1;
        end
        MSG_PROGRAM: begin
          ev_hit    = 1'b1;
          ev.kind   = EV_PROGRAM;
          ev.number = d1;
        end
        MSG_BEND: begin
          ev_hit   = 1'b1;
          ev.kind  = EV_BEND;
          ev.value = {d2, d1};
        end
        MSG_CTRL: begin
          ev.value = {7'd0, d2};
          unique case (d1)
            CC_MODULATION: begin
              ev_hit  = 1'b1;
              ev.kind = EV_MODULATION;
            end
            CC_VOLUME: begin
              ev_hit  = 1'b1;
              ev.kind = EV_VOLUME;
            end
            CC_EXPRESSION: begin
              ev_hit  = 1'b1;
              ev.kind = EV_EXPRESSION;
            end
            CC_HOLD: begin
              ev_hit  = 1'b1;
              ev.kind = EV_HOLD;
            end
            CC_SOUND_OFF: begin
              ev_hit   = 1'b1;
              ev.kind  = EV_SOUND_OFF;
              ev.value = '0;
            end
            CC_NOTES_OFF: begin
              ev_hit   = 1'b1;
              ev.kind  = EV_NOTES_OFF;
              ev.value = '0;
            end
            CC_RPN_MSB: st_nxt.rpn_high = d2;
            CC_RPN_LSB: st_nxt.rpn_low  = d2;
            CC_DATA_ENTRY: begin
              ev_hit          = (st.rpn_high == 7'd0) && (st.rpn_low == 7'd0);
              ev.kind         = EV_BEND_SENS;
              st_nxt.rpn_high = RPN_NULL;
              st_nxt.rpn_low  = RPN_NULL;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/midi_message_decoder.sv
// Each accepted input beat passes through the input register, then decode into
// the result register. Throughput: one beat per cycle; the single decode pass
// bounds it, and it holds while out_stall is low.
// Reset (rst_n low, synchronous) empties both registers, drops running status
// and system exclusive mode, and sets the RPN to 7F/7F.
module midi_message_decoder #(
  parameter int MAX_SYSEX_LEN = mmd_pkg::DEFAULT_MAX_SYSEX_LEN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [3:0]                 out_event_kind,
  output logic [3:0]                 out_channel,
  output logic [6:0]                 out_number,
  output logic [13:0]                out_value,
  output logic [mmd_pkg::LEN_W-1:0]  out_sysex_length
);
  import mmd_pkg::*;

  // Input register: one received byte waiting for decode
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // Decoder state carried between bytes
  state_t st_r;
  state_t st_nxt;

  // Result register
  logic   out_vld_r;
  event_t out_ev_r;

  logic   ev_hit;
  event_t ev;
  logic   advance;

  mmd_decode #(
    .MAX_SYSEX_LEN(MAX_SYSEX_LEN)
  ) u_decode (
    .rx_byte(in_byte_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .ev_hit (ev_hit),
    .ev     (ev)
  );

  // Advance the held byte when the result register has room for its event,
  // or when the byte yields no event at all (state update only).
  assign advance  = in_vld_r && (!out_vld_r || !out_stall || !ev_hit);
  // Hold the input side only while a byte sits blocked in the input register.
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.running_status <= ST_NONE;
      st_r.await_third    <= 1'b0;
      st_r.first_data     <= '0;
      st_r.rpn_high       <= RPN_NULL;
      st_r.rpn_low        <= RPN_NULL;
      st_r.in_sysex       <= 1'b0;
      st_r.sysex_count    <= '0;
      st_r.pattern_match  <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Load a new event when one is produced; otherwise drop the old one once
  // the far side has taken it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && ev_hit) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ev_hit) begin
      out_ev_r <= ev;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_event_kind   = out_ev_r.kind;
  assign out_channel      = out_ev_r.channel;
  assign out_number       = out_ev_r.number;
  assign out_value        = out_ev_r.value;
  assign out_sysex_length = out_ev_r.sysex_length;

endmodule

### dv/midi_message_decoder_test.sv
`timescale 1ns / 1ps

package mmd_check_pkg;
  import mmd_pkg::*;

  // Reset sysex payload prefixes, first byte in the top octet
  localparam logic [31:0] GM_SEQ = 32'h7E7F0901;
  localparam logic [55:0] XG_SEQ = 56'h43104C00007E00;
  localparam logic [71:0] GS_SEQ = 72'h4110421240007F0041;

  localparam int SEQ_GM = 0;
  localparam int SEQ_XG = 1;
  localparam int SEQ_GS = 2;

  function automatic int unsigned seq_len(int which);
    case (which)
      SEQ_GM: return 4;
      SEQ_XG: return 7;
      default: return 9;
    endcase
  endfunction

  function automatic logic [7:0] seq_byte(int which, int i);
    case (which)
      SEQ_GM: return GM_SEQ[31 - 8*i -: 8];
      SEQ_XG: return XG_SEQ[55 - 8*i -: 8];
      default: return GS_SEQ[71 - 8*i -: 8];
    endcase
  endfunction

  class midi_event_board;
    state_t      ctx;
    event_t      owed[$];
    int unsigned faults;
    int unsigned len_cap;

    function new(int unsigned max_len);
      len_cap      = (max_len > COUNT_MAX) ? COUNT_MAX : max_len;
      ctx          = '0;
      ctx.rpn_high = RPN_NULL;
      ctx.rpn_low  = RPN_NULL;
      faults       = 0;
    endfunction

    function int unsigned outstanding();
      return owed.size();
    endfunction

    function void owe(event_kind_t kind, logic [3:0] ch, logic [6:0] num,
                      logic [13:0] val, logic [LEN_W-1:0] len);
      event_t ev;
      ev.kind         = kind;
      ev.channel      = ch;
      ev.number       = num;
      ev.value        = val;
      ev.sysex_length = len;
      owed.insert(owed.size(), ev);
    endfunction

    function void decode_pair(logic [6:0] d1, logic [6:0] d2);
      logic [3:0] ch;
      logic       hit;
      ch = ctx.running_status[3:0];
      case (ctx.running_status[7:4])
        MSG_NOTE_ON: begin
          if (d2 == 7'd0) begin
            owe(EV_NOTE_OFF, ch, d1, '0, '0);
          end else begin
            owe(EV_NOTE_ON, ch, d1, {7'd0, d2}, '0);
          end
        end
        MSG_NOTE_OFF: owe(EV_NOTE_OFF, ch, d1, '0, '0);
        MSG_PROGRAM:  owe(EV_PROGRAM, ch, d1, '0, '0);
        MSG_BEND:     owe(EV_BEND, ch, '0, {d2, d1}, '0);
        MSG_CTRL: begin
          case (d1)
            CC_MODULATION: owe(EV_MODULATION, ch, '0, {7'd0, d2}, '0);
            CC_VOLUME:     owe(EV_VOLUME, ch, '0, {7'd0, d2}, '0);
            CC_EXPRESSION: owe(EV_EXPRESSION, ch, '0, {7'd0, d2}, '0);
            CC_HOLD:       owe(EV_HOLD, ch, '0, {7'd0, d2}, '0);
            CC_SOUND_OFF:  owe(EV_SOUND_OFF, ch, '0, '0, '0);
            CC_NOTES_OFF:  owe(EV_NOTES_OFF, ch, '0, '0, '0);
            CC_RPN_MSB:    ctx.rpn_high = d2;
            CC_RPN_LSB:    ctx.rpn_low = d2;
            CC_DATA_ENTRY: begin
              hit          = (ctx.rpn_high == 7'd0) && (ctx.rpn_low == 7'd0);
              ctx.rpn_high = RPN_NULL;
              ctx.rpn_low  = RPN_NULL;
              if (hit) begin
                owe(EV_BEND_SENS, ch, '0, {7'd0, d2}, '0);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      int   s;
      logic reset_hit;
      if (ctx.in_sysex) begin
        if (b == ST_EOX) begin
          ctx.in_sysex = 1'b0;
          reset_hit    = 1'b0;
          for (s = SEQ_GM; s <= SEQ_GS; s++) begin
            if (ctx.pattern_match[s] && ctx.sysex_count >= seq_len(s)) reset_hit = 1'b1;
          end
          if (reset_hit) begin
            owe(EV_RESET, '0, '0, '0, '0);
          end else begin
            owe(EV_SYSEX_END, '0, '0, '0, ctx.sysex_count);
          end
        end else begin
          for (s = SEQ_GM; s <= SEQ_GS; s++) begin
            if (ctx.sysex_count < seq_len(s)) begin
              if (seq_byte(s, ctx.sysex_count) != b) ctx.pattern_match[s] = 1'b0;
            end
          end
          if (ctx.sysex_count < len_cap) ctx.sysex_count = ctx.sysex_count + LEN_W'(1);
          owe(EV_SYSEX_BYTE, '0, '0, {6'd0, b}, '0);
        end
      end else if (b == ST_SYSEX) begin
        ctx.in_sysex       = 1'b1;
        ctx.sysex_count    = '0;
        ctx.pattern_match  = 3'b111;
        ctx.running_status = ST_NONE;
        ctx.await_third    = 1'b0;
      end else if (b >= ST_REALTIME) begin
        // realtime: no effect
      end else if (b >= ST_COMMON) begin
        ctx.running_status = ST_NONE;
        ctx.await_third    = 1'b0;
      end else if (b[7]) begin
        ctx.running_status = b;
        ctx.await_third    = 1'b0;
      end else if (ctx.await_third) begin
        ctx.await_third = 1'b0;
        decode_pair(ctx.first_data, b[6:0]);
      end else if (ctx.running_status != ST_NONE) begin
        if (ctx.running_status[7:4] == MSG_PROGRAM ||
            ctx.running_status[7:4] == MSG_CHAN_PRS) begin
          decode_pair(b[6:0], 7'd0);
        end else begin
          ctx.first_data  = b[6:0];
          ctx.await_third = 1'b1;
        end
      end
    endfunction

    function void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
        faults++;
      end
    endfunction

    function void check_event(event_t got);
      event_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected event kind %0d ch %0d num %0d value %0d length %0d",
                 $time, got.kind, got.channel, got.number, got.value, got.sysex_length);
        faults++;
        return;
      end
      want = owed.pop_front();
      check_field("event_kind", 16'(want.kind), 16'(got.kind));
      check_field("channel", 16'(want.channel), 16'(got.channel));
      check_field("number", 16'(want.number), 16'(got.number));
      check_field("value", 16'(want.value), 16'(got.value));
      check_field("sysex_length", 16'(want.sysex_length), 16'(got.sysex_length));
    endfunction
  endclass

endpackage

module midi_message_decoder_test;
  import mmd_pkg::*;
  import mmd_check_pkg::*;

  localparam int          SYSEX_CAP      = DEFAULT_MAX_SYSEX_LEN;
  localparam int unsigned RANDOM_ITEMS   = 400;
  localparam int unsigned SQUEEZE_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT    = 400_000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_rx_byte;
  logic              out_valid;
  logic              out_stall;
  logic [3:0]        out_event_kind;
  logic [3:0]        out_channel;
  logic [6:0]        out_number;
  logic [13:0]       out_value;
  logic [LEN_W-1:0]  out_sysex_length;

  midi_event_board board;
  event_t          seen;
  int unsigned     stim_count  = 0;
  int unsigned     cycle_count = 0;
  int unsigned     fast_left   = 0;
  bit              src_calm    = 1'b0;
  bit              sink_calm   = 1'b0;
  bit              squeeze_req = 1'b0;

  midi_message_decoder #(
    .MAX_SYSEX_LEN(SYSEX_CAP)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_channel     (out_channel),
    .out_number      (out_number),
    .out_value       (out_value),
    .out_sysex_length(out_sysex_length)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Abandon the run if it outlasts the cycle limit, as when the block stops moving beats
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Sample every accepted result beat and hand it to the board; outputs and
  // out_stall are both read before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.kind         = event_kind_t'(out_event_kind);
      seen.channel      = out_channel;
      seen.number       = out_number;
      seen.value        = out_value;
      seen.sysex_length = out_sysex_length;
      board.check_event(seen);
    end
  end

  // Data byte biased towards its extremes
  function automatic logic [6:0] rand_data();
    case ($urandom_range(0, 7))
      0: return 7'h00;
      1: return 7'h7F;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // Offer one byte, idling first for a drawn number of cycles, and hold it
  // until the block takes the beat.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
    if (fast_left != 0) begin
      fast_left--;
      gap = 0;
    end else begin
      gap = src_calm ? 0 : $urandom_range(0, 16);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    board.note_byte(b);
    if (b < ST_REALTIME) stim_count++;
  endtask

  // Drop valid and wait until every owed event has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  // One system exclusive exchange: a reset prefix (whole, cut short or with
  // one byte spoilt) or none, then a random tail, then the end byte.
  task automatic send_sysex();
    int unsigned shape;
    int unsigned plen;
    int unsigned tail;
    int unsigned bad_at;
    int unsigned i;
    int          which;
    logic [7:0]  b;
    shape = $urandom_range(0, 4);
    which = $urandom_range(SEQ_GM, SEQ_GS);
    case (shape)
      0, 1:    plen = seq_len(which);
      2:       plen = $urandom_range(0, seq_len(which) - 1);
      3:       plen = seq_len(which);
      default: plen = 0;
    endcase
    bad_at = (shape == 3) ? $urandom_range(0, plen - 1) : plen;
    send_byte(ST_SYSEX);
    for (i = 0; i < plen; i++) begin
      b = seq_byte(which, i);
      if (i == bad_at) b = b ^ 8'h01;
      send_byte(b);
    end
    tail = (shape == 0) ? $urandom_range(0, 2) : $urandom_range(0, 12);
    for (i = 0; i < tail; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        // status and realtime bytes are payload here too, all but the end byte
        b = 8'($urandom_range(0, 255));
        if (b == ST_EOX) b = ST_SYSEX;
      end else begin
        b = {1'b0, rand_data()};
      end
      send_byte(b);
    end
    send_byte(ST_EOX);
  endtask

  // Mostly well-formed traffic with random content; the rest is noise and
  // messages cut short by a fresh status byte.
  task automatic send_random_message();
    int unsigned pick;
    logic [2:0]  op;
    logic [3:0]  ch;
    logic [3:0]  msg;
    logic [6:0]  first;
    pick = $urandom_range(0, 99);
    op   = 3'($urandom_range(0, 6));
    ch   = 4'($urandom_range(0, 15));
    msg  = {1'b1, op};
    if (pick < 55) begin
      // leave the status out now and then to lean on running status
      if ($urandom_range(0, 3) != 0) send_byte({msg, ch});
      if (msg == MSG_CTRL) begin
        case ($urandom_range(0, 11))
          0:       first = CC_MODULATION;
          1:       first = CC_VOLUME;
          2:       first = CC_EXPRESSION;
          3:       first = CC_HOLD;
          4:       first = CC_SOUND_OFF;
          5:       first = CC_NOTES_OFF;
          6:       first = CC_DATA_ENTRY;
          7:       first = CC_RPN_LSB;
          8:       first = CC_RPN_MSB;
          default: first = rand_data();
        endcase
      end else begin
        first = rand_data();
      end
      send_byte({1'b0, first});
      if ($urandom_range(0, 15) == 0) send_byte(ST_REALTIME | 8'($urandom_range(0, 7)));
      if (msg != MSG_PROGRAM && msg != MSG_CHAN_PRS) begin
        if (msg == MSG_NOTE_ON && $urandom_range(0, 3) == 0) begin
          send_byte(8'h00);
        end else begin
          send_byte({1'b0, rand_data()});
        end
      end
    end else if (pick < 65) begin
      // select an RPN, mostly bend sensitivity, then enter data
      send_byte({MSG_CTRL, ch});
      send_byte({1'b0, CC_RPN_MSB});
      send_byte({1'b0, ($urandom_range(0, 3) != 0) ? 7'd0 : rand_data()});
      send_byte({1'b0, CC_RPN_LSB});
      send_byte({1'b0, ($urandom_range(0, 3) != 0) ? 7'd0 : rand_data()});
      send_byte({1'b0, CC_DATA_ENTRY});
      send_byte({1'b0, rand_data()});
    end else if (pick < 85) begin
      send_sysex();
    end else begin
      case ($urandom_range(0, 3))
        0: send_byte(8'($urandom_range(0, 255)));
        1: send_byte(ST_REALTIME | 8'($urandom_range(0, 7)));
        2: send_byte(8'($urandom_range(ST_COMMON, ST_EOX)));
        default: begin
          send_byte({msg, ch});
          send_byte({1'b0, rand_data()});
          send_byte({1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))});
        end
      endcase
    end
  endtask

  // Result side: draw a stall before each beat, and once hold off for a long
  // stretch so that the block backs up into its input.
  initial begin : result_sink
    int unsigned hold;
    out_stall <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall <= 1'b1;
        hold = 0;
        while (hold < SQUEEZE_CYCLES) begin
          @(posedge clk);
          hold++;
        end
      end
      hold = sink_calm ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    bit squeezed;
    bit paused;
    squeezed = 1'b0;
    paused   = 1'b0;
    board = new(SYSEX_CAP);
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: every channel message event kind, sysex end, field extremes and the odd cases
    send_byte(8'h45);                               // data with no running status: drop
    send_byte({MSG_NOTE_ON, 4'h0});
    send_byte(8'h00); send_byte(8'h7F);             // note on, lowest note, top velocity
    send_byte(8'h00); send_byte(8'h00);             // running status, zero velocity
    send_byte({MSG_NOTE_OFF, 4'hF});
    send_byte(8'h7F); send_byte(8'h40);
    send_byte({MSG_PROGRAM, 4'hF}); send_byte(8'h7F);
    send_byte({MSG_BEND, 4'h0});
    send_byte(8'h7F); send_byte(8'h7F);             // full-scale bend
    send_byte({MSG_CTRL, 4'h9});
    send_byte({1'b0, CC_MODULATION}); send_byte(8'h7F);
    send_byte({1'b0, CC_VOLUME});     send_byte(8'h00);
    send_byte({1'b0, CC_EXPRESSION}); send_byte(8'h40);
    send_byte({1'b0, CC_HOLD});       send_byte(8'h7F);
    send_byte({1'b0, CC_SOUND_OFF});  send_byte(8'h00);
    send_byte({1'b0, CC_NOTES_OFF});  send_byte(8'h00);
    send_byte({1'b0, CC_RPN_MSB});    send_byte(8'h00);
    send_byte({1'b0, CC_RPN_LSB});    send_byte(8'h00);
    send_byte({1'b0, CC_DATA_ENTRY}); send_byte(8'h7F);  // bend sensitivity
    send_byte({1'b0, CC_DATA_ENTRY}); send_byte(8'h05);  // RPN now null: nothing
    send_byte(8'hFF);                               // realtime: ignore
    send_byte(ST_COMMON);                           // system common clears running status
    send_byte(8'h10);
    send_byte(ST_SYSEX); send_byte(ST_EOX);         // empty exchange, length zero
    drain();

    stim_count = 0;
    while (stim_count < RANDOM_ITEMS) begin
      if (!squeezed && stim_count >= 150) begin
        // keep offering back to back while the result side holds off
        squeezed    = 1'b1;
        squeeze_req = 1'b1;
        fast_left   = 80;
      end
      if (!paused && stim_count >= 300) begin
        paused = 1'b1;
        drain();
      end
      send_random_message();
    end

    drain();
    repeat (40) @(posedge clk);
    if (board.faults == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
